>>> rtl/core/hab_pkg.sv
// ----------------------------------------------------------------------------
// hab_pkg
// Types and character constants shared by the angle-bracket escaper modules.
// ----------------------------------------------------------------------------
package hab_pkg;

   typedef logic [7:0] byte_type;

   // one input position: window[0] is the current byte, window[8:1] look ahead
   typedef struct packed {
      logic                buffer_start;
      byte_type [8:0]      window;
   } req_type;

   // up to four characters, index 0 goes out first
   typedef logic [3:0][7:0] quad_type;

   typedef logic [2:0] len_type;
   typedef logic [1:0] skip_type;

   // characters produced by one word
   typedef struct packed {
      len_type  len;
      quad_type chars;
   } seq_type;

   localparam len_type  LEN_NONE = 3'd0;
   localparam len_type  LEN_ONE  = 3'd1;
   localparam len_type  LEN_QUAD = 3'd4;

   localparam skip_type SKIP_NONE        = 2'd0;
   localparam skip_type SKIP_AFTER_CLOSE = 2'd3;

   // ascii codes
   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_SP    = 8'h20;
   localparam byte_type CH_QUOTE = 8'h22;
   localparam byte_type CH_AMP   = 8'h26;
   localparam byte_type CH_SLASH = 8'h2F;
   localparam byte_type CH_SEMI  = 8'h3B;
   localparam byte_type CH_LT    = 8'h3C;
   localparam byte_type CH_EQ    = 8'h3D;
   localparam byte_type CH_GT    = 8'h3E;
   localparam byte_type CH_A     = 8'h61;
   localparam byte_type CH_B     = 8'h62;
   localparam byte_type CH_E     = 8'h65;
   localparam byte_type CH_F     = 8'h66;
   localparam byte_type CH_G     = 8'h67;
   localparam byte_type CH_H     = 8'h68;
   localparam byte_type CH_L     = 8'h6C;
   localparam byte_type CH_P     = 8'h70;
   localparam byte_type CH_R     = 8'h72;
   localparam byte_type CH_T     = 8'h74;

   // patterns, lowest index is the first character
   localparam quad_type BR_PAT    = {CH_GT, CH_R, CH_B, CH_LT};
   localparam byte_type [4:0] PRE_PAT = {CH_GT, CH_E, CH_R, CH_P, CH_LT};
   localparam byte_type [8:0] AHREF_PAT =
      {CH_QUOTE, CH_EQ, CH_F, CH_E, CH_R, CH_H, CH_SP, CH_A, CH_LT};
   localparam quad_type CLOSE_SEQ = {CH_GT, CH_A, CH_SLASH, CH_LT};
   localparam quad_type LT_SEQ    = {CH_SEMI, CH_T, CH_L, CH_AMP};
   localparam quad_type GT_SEQ    = {CH_SEMI, CH_T, CH_G, CH_AMP};

endpackage

>>> rtl/core/hab_decode.sv
// ----------------------------------------------------------------------------
// hab_decode
// Classifies the registered input position against the buffer state and
// builds the character sequence it produces; holds the buffer state.
// ----------------------------------------------------------------------------
module hab_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  hab_pkg::req_type in_word,
   input  logic             seq_ready,
   output logic             take,
   output logic             seq_valid,
   output hab_pkg::seq_type seq
);

   logic              raw_mode_ff, raw_mode_in;
   logic              in_link_ff, in_link_in;
   hab_pkg::skip_type skip_count_ff, skip_count_in;
   logic              buffer_ended_ff, buffer_ended_in;

   logic              raw_prefix;
   logic              raw_eff, link_eff, ended_eff;
   hab_pkg::skip_type skip_eff;
   hab_pkg::byte_type cur;

   assign cur = in_word.window[0];

   // buffer opens with <br> or <pre>
   assign raw_prefix = (in_word.window[3:0] == hab_pkg::BR_PAT) ||
                       (in_word.window[4:0] == hab_pkg::PRE_PAT);

   // state as seen by this word, after a buffer start
   always_comb begin
      raw_eff   = in_word.buffer_start ? raw_prefix : raw_mode_ff;
      link_eff  = in_word.buffer_start ? 1'b0 : in_link_ff;
      skip_eff  = in_word.buffer_start ? hab_pkg::SKIP_NONE : skip_count_ff;
      ended_eff = in_word.buffer_start ? 1'b0 : buffer_ended_ff;
   end

   // character decision and next state
   always_comb begin
      raw_mode_in     = raw_eff;
      in_link_in      = link_eff;
      skip_count_in   = skip_eff;
      buffer_ended_in = ended_eff;
      seq.len         = hab_pkg::LEN_NONE;
      seq.chars       = {hab_pkg::CH_NUL, hab_pkg::CH_NUL, hab_pkg::CH_NUL, cur};
      if (ended_eff) begin
         seq.len = hab_pkg::LEN_NONE;
      end else if (skip_eff != hab_pkg::SKIP_NONE) begin
         skip_count_in = skip_eff - 2'd1;
      end else if (cur == hab_pkg::CH_NUL) begin
         buffer_ended_in = 1'b1;
      end else if (raw_eff) begin
         seq.len = hab_pkg::LEN_ONE;
      end else if (cur == hab_pkg::CH_LT) begin
         if (in_word.window == hab_pkg::AHREF_PAT) begin
            in_link_in = 1'b1;
            seq.len    = hab_pkg::LEN_ONE;
         end else if (link_eff && (in_word.window[3:0] == hab_pkg::CLOSE_SEQ)) begin
            in_link_in    = 1'b0;
            skip_count_in = hab_pkg::SKIP_AFTER_CLOSE;
            seq.len       = hab_pkg::LEN_QUAD;
            seq.chars     = hab_pkg::CLOSE_SEQ;
         end else begin
            in_link_in = 1'b0;
            seq.len    = hab_pkg::LEN_QUAD;
            seq.chars  = hab_pkg::LT_SEQ;
         end
      end else if (cur == hab_pkg::CH_GT) begin
         if (!link_eff) begin
            seq.len   = hab_pkg::LEN_QUAD;
            seq.chars = hab_pkg::GT_SEQ;
         end else begin
            seq.len = hab_pkg::LEN_ONE;
         end
      end else begin
         seq.len = hab_pkg::LEN_ONE;
      end
   end

   // words with no characters never wait on the emitter
   assign take      = in_valid && ((seq.len == hab_pkg::LEN_NONE) || seq_ready);
   assign seq_valid = in_valid && (seq.len != hab_pkg::LEN_NONE);

   // buffer state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff     <= 1'b0;
         in_link_ff      <= 1'b0;
         skip_count_ff   <= hab_pkg::SKIP_NONE;
         buffer_ended_ff <= 1'b0;
      end else if (take) begin
         raw_mode_ff     <= raw_mode_in;
         in_link_ff      <= in_link_in;
         skip_count_ff   <= skip_count_in;
         buffer_ended_ff <= buffer_ended_in;
      end
   end

   // a skip run only follows a closing tag, which leaves the link
   a_skip_no_link: assert property (@(posedge clock) disable iff (reset)
      (skip_count_ff != hab_pkg::SKIP_NONE) |-> !in_link_ff)
      else $error("skip pending while inside a link");

   // raw buffers never enter a link
   a_raw_no_link: assert property (@(posedge clock) disable iff (reset)
      raw_mode_ff |-> !in_link_ff)
      else $error("link flag set in raw buffer");

   // an ended buffer has no skip left
   a_ended_no_skip: assert property (@(posedge clock) disable iff (reset)
      buffer_ended_ff |-> (skip_count_ff == hab_pkg::SKIP_NONE))
      else $error("skip pending after end of buffer");

endmodule

>>> rtl/core/hab_emit.sv
// ----------------------------------------------------------------------------
// hab_emit
// Holds one character sequence and sends it out one character per word,
// marking the last one.
// ----------------------------------------------------------------------------
module hab_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              seq_valid,
   input  hab_pkg::seq_type  seq,
   output logic              seq_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hab_pkg::byte_type rsp_out_char,
   output logic              rsp_last_char
);

   hab_pkg::len_type  len_ff;
   hab_pkg::quad_type chars_ff;
   logic [1:0]        idx_ff;
   logic              last;
   logic              fire;

   assign rsp_valid     = (len_ff != hab_pkg::LEN_NONE);
   assign last          = ({1'b0, idx_ff} == (len_ff - 3'd1));
   assign fire          = rsp_valid && rsp_ready;
   assign rsp_out_char  = chars_ff[idx_ff];
   assign rsp_last_char = last;

   // free now, or freed by the last character leaving this cycle
   assign seq_ready = !rsp_valid || (fire && last);

   // sequence register and character pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= hab_pkg::LEN_NONE;
         idx_ff <= 2'd0;
      end else if (seq_valid && seq_ready) begin
         len_ff <= seq.len;
         idx_ff <= 2'd0;
      end else if (fire && last) begin
         len_ff <= hab_pkg::LEN_NONE;
         idx_ff <= 2'd0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_valid && seq_ready) begin
         chars_ff <= seq.chars;
      end
   end

   // only single characters and four-character runs are held
   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      (len_ff == hab_pkg::LEN_NONE) || (len_ff == hab_pkg::LEN_ONE) ||
      (len_ff == hab_pkg::LEN_QUAD))
      else $error("illegal sequence length");

   // a stalled character keeps its position
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(idx_ff) && $stable(len_ff))
      else $error("character pointer moved under stall");

   // an idle emitter always takes a new sequence
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> seq_ready)
      else $error("idle emitter refused a sequence");

endmodule

>>> rtl/core/html_angle_bracket_escaper.sv
// ----------------------------------------------------------------------------
// html_angle_bracket_escaper
// Escapes '<' and '>' in a text buffer presented one position per word,
// passing raw buffers, link openers and link closers unchanged.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | current_byte, ahead_1..ahead_8, buffer_start
//  rsp     | out | out_char, last_char
//
//  one plain character per cycle while rsp is ready; an escaped bracket or a closing tag
//  is sent as four characters through the one-character-per-cycle result port
//  positions that give no character are consumed without waiting on rsp
//  first character is offered from the emitter's sequence register, loaded as the decoder takes the position
//  reset clears the buffer state, the input register and the emitter
//  a stall on rsp holds the current character and backs up into req
module html_angle_bracket_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_current_byte,
   input  logic [7:0] req_ahead_1,
   input  logic [7:0] req_ahead_2,
   input  logic [7:0] req_ahead_3,
   input  logic [7:0] req_ahead_4,
   input  logic [7:0] req_ahead_5,
   input  logic [7:0] req_ahead_6,
   input  logic [7:0] req_ahead_7,
   input  logic [7:0] req_ahead_8,
   input  logic       req_buffer_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   hab_pkg::req_type in_ff;
   logic             in_valid_ff;
   logic             take;
   logic             seq_valid;
   logic             seq_ready;
   hab_pkg::seq_type seq;

   assign req_ready = !in_valid_ff || take;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.buffer_start <= req_buffer_start;
         in_ff.window       <= {req_ahead_8, req_ahead_7, req_ahead_6, req_ahead_5,
                                req_ahead_4, req_ahead_3, req_ahead_2, req_ahead_1,
                                req_current_byte};
      end
   end

   // classify and update buffer state
   hab_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_word   (in_ff),
      .seq_ready (seq_ready),
      .take      (take),
      .seq_valid (seq_valid),
      .seq       (seq)
   );

   // send characters
   hab_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .seq_valid     (seq_valid),
      .seq           (seq),
      .seq_ready     (seq_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
